>>> sv/assert_macros.svh
// Assertion macros used by the top-level RTL file of the cursor list free pool.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset.
`define CLFP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never be true outside reset.
`define CLFP_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CLFP_ASSERT(label, clk, rst_n, prop, msg)
`define CLFP_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

>>> sv/clfp_pkg.sv
// Package with the sizes, codes and helper functions of the cursor list free pool.
`default_nettype none
package clfp_pkg;

    // Number of cells in the pool.
    localparam int POOL_CELLS = 16;
    // Bits of a cell address, and of a link that can also hold the null code.
    localparam int CELL_W = (POOL_CELLS > 1) ? $clog2(POOL_CELLS) : 1;
    localparam int LINK_W = CELL_W + 1;
    // Bits of the walk step counter, which must reach POOL_CELLS itself.
    localparam int STEP_W = $clog2(POOL_CELLS + 1);

    // Fixed widths of the word fields.
    localparam int MODE_W     = 2;
    localparam int VALUE_W    = 32;
    localparam int CELL_IDX_W = 4;

    typedef logic [LINK_W-1:0]     t_link;
    typedef logic [CELL_W-1:0]     t_cell;
    typedef logic [MODE_W-1:0]     t_mode;
    typedef logic [CELL_IDX_W-1:0] t_cell_idx;

    // The null link is coded as the pool size.
    localparam t_link NULL_LINK = t_link'(POOL_CELLS);

    // Operation codes.
    localparam t_mode MODE_FRONT  = 2'd0;
    localparam t_mode MODE_BACK   = 2'd1;
    localparam t_mode MODE_RETURN = 2'd2;

    // Status codes.
    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // True when a link names a real cell rather than null or beyond.
    function automatic logic is_cell(input t_link lnk);
        return lnk < NULL_LINK;
    endfunction

    // Link held by a cell after reset: the next cell, the last one null.
    function automatic t_link reset_link(input t_cell addr);
        return t_link'(addr) + t_link'(1);
    endfunction

endpackage
`default_nettype wire

>>> sv/clfp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module clfp_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

>>> sv/cursor_list_free_pool.sv
// Top level of the cursor list free pool: control sequencer around the link and value RAMs.
// A fixed pool of cells, each with a 32-bit value and a link, holds a free list and one
// user list. Each input word inserts a value at the front of the list, inserts it at the
// back, or returns a cell to the free list; every word yields exactly one result word with
// a status (done, or pool full) and the cell taken or released. Returning a cell does not
// unlink it from the list, so loops are possible; the walk to the tail stops after
// POOL_CELLS steps. The links live in a RAM with a registered read, and its reset
// contents are supplied by a valid bit per entry, so no clearing pass is needed after reset.
// Each accepted word goes to S_START. A return, the unused mode or a refused insert then
// goes to S_DONE; an insert at the front or an insert at the back onto an empty list goes
// through S_TAKE to S_DONE; an insert at the back onto a non-empty list goes through S_TAKE
// and then S_WALK, which reaches the tail by one link RAM read per cycle (at most POOL_CELLS
// cells passed), then S_DONE, which loads the result word once the output register is free.
// The input stalls until the result word is loaded and the next word can be accepted at the
// following edge. The next word is taken once the previous result has moved into the
// output register, even if that register is still stalled.
`default_nettype none
`include "assert_macros.svh"
module cursor_list_free_pool (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire clfp_pkg::t_mode           i_mode,
    input  wire logic signed [31:0]        i_value,
    input  wire clfp_pkg::t_cell_idx       i_cell_index,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic                           o_status,
    output clfp_pkg::t_cell_idx            o_cell_used
);
    import clfp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_TAKE,
        S_WALK,
        S_DONE
    } t_state;

    t_state                  r_state;
    t_mode                   r_mode;
    logic signed [VALUE_W-1:0] r_value;
    t_cell_idx               r_idx;
    t_link                   r_free_head;
    t_link                   r_list_head;
    t_link                   r_new_cell;
    t_link                   r_trav;
    logic [STEP_W-1:0]       r_steps;
    logic                    r_res_status;
    t_cell_idx               r_res_cell;
    logic [POOL_CELLS-1:0]   r_link_valid;

    // Read-side bookkeeping for the link RAM: address, valid bit and forwarding.
    t_cell                   r_rd_addr;
    logic                    r_rd_valid;
    logic                    r_fwd_hit;
    t_link                   r_fwd_data;

    // Link RAM ports.
    logic                    link_we;
    t_cell                   link_waddr;
    t_link                   link_wdata;
    t_cell                   link_raddr;
    t_link                   link_ram_q;
    t_link                   link_rdata;

    // Value RAM write port.
    logic                    val_we;
    t_cell                   val_waddr;

    logic                    idx_is_cell;
    logic                    walk_more;

    assign o_in_stall = (r_state != S_IDLE);

    // The returned cell must lie inside the pool.
    assign idx_is_cell = is_cell(t_link'(r_idx)) && (int'(r_idx) < POOL_CELLS);

    // Link as seen by the logic: a write to the same entry in the read cycle wins, and an
    // entry never written since reset reads as its reset link.
    always_comb begin
        if (r_fwd_hit) begin
            link_rdata = r_fwd_data;
        end else if (r_rd_valid) begin
            link_rdata = link_ram_q;
        end else begin
            link_rdata = reset_link(r_rd_addr);
        end
    end

    assign walk_more = is_cell(link_rdata) && (r_steps < STEP_W'(POOL_CELLS));

    // Addresses and write enables of both RAMs for the current step.
    always_comb begin
        link_we    = 1'b0;
        link_waddr = CELL_W'(r_trav);
        link_wdata = NULL_LINK;
        link_raddr = CELL_W'(r_free_head);
        val_we     = 1'b0;
        val_waddr  = CELL_W'(r_free_head);
        case (r_state)
            S_START: begin
                // Fetch the link of the free head for a possible insert.
                link_raddr = CELL_W'(r_free_head);
                if (r_mode == MODE_RETURN && idx_is_cell) begin
                    link_we    = 1'b1;
                    link_waddr = CELL_W'(r_idx);
                    link_wdata = r_free_head;
                end
            end
            S_TAKE: begin
                // The taken cell gets its value and its new link; the list head is read
                // in case the tail has to be found.
                val_we     = 1'b1;
                val_waddr  = CELL_W'(r_free_head);
                link_we    = 1'b1;
                link_waddr = CELL_W'(r_free_head);
                link_wdata = (r_mode == MODE_FRONT) ? r_list_head : NULL_LINK;
                link_raddr = CELL_W'(r_list_head);
            end
            S_WALK: begin
                if (walk_more) begin
                    link_raddr = CELL_W'(link_rdata);
                end else begin
                    link_we    = 1'b1;
                    link_waddr = CELL_W'(r_trav);
                    link_wdata = r_new_cell;
                end
            end
            default: begin
            end
        endcase
    end

    clfp_ram #(
        .WIDTH (LINK_W),
        .DEPTH (POOL_CELLS)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (link_we),
        .i_wr_addr (link_waddr),
        .i_wr_data (link_wdata),
        .i_rd_addr (link_raddr),
        .o_rd_data (link_ram_q)
    );

    // Cell values are stored by every insert that takes a cell; no result word carries them.
    clfp_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (POOL_CELLS)
    ) u_value_ram (
        .i_clk     (i_clk),
        .i_wr_en   (val_we),
        .i_wr_addr (val_waddr),
        .i_wr_data (r_value),
        .i_rd_addr (link_raddr),
        .o_rd_data ()
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_free_head  <= '0;
            r_list_head  <= NULL_LINK;
            r_link_valid <= '0;
            r_fwd_hit    <= 1'b0;
            r_rd_valid   <= 1'b0;
            r_steps      <= '0;
            o_out_valid  <= 1'b0;
        end else begin
            // Read-side tracking for the link RAM.
            r_rd_addr  <= link_raddr;
            r_rd_valid <= r_link_valid[link_raddr];
            r_fwd_hit  <= link_we && (link_waddr == link_raddr);
            r_fwd_data <= link_wdata;
            if (link_we) begin
                r_link_valid[link_waddr] <= 1'b1;
            end

            // A word taken by the receiver empties the output register, unless a new
            // result word is loaded in the same cycle.
            if (o_out_valid && !i_out_stall && r_state != S_DONE) begin
                o_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_mode  <= i_mode;
                        r_value <= i_value;
                        r_idx   <= i_cell_index;
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    case (r_mode)
                        MODE_FRONT, MODE_BACK: begin
                            if (!is_cell(r_free_head)) begin
                                r_res_status <= STATUS_FULL;
                                r_res_cell   <= '0;
                                r_state      <= S_DONE;
                            end else begin
                                r_res_status <= STATUS_DONE;
                                r_res_cell   <= CELL_IDX_W'(r_free_head);
                                r_state      <= S_TAKE;
                            end
                        end
                        MODE_RETURN: begin
                            r_res_status <= STATUS_DONE;
                            r_res_cell   <= r_idx;
                            r_state      <= S_DONE;
                            if (idx_is_cell) begin
                                r_free_head <= t_link'(r_idx);
                            end
                        end
                        default: begin
                            r_res_status <= STATUS_DONE;
                            r_res_cell   <= '0;
                            r_state      <= S_DONE;
                        end
                    endcase
                end
                S_TAKE: begin
                    r_new_cell  <= r_free_head;
                    r_free_head <= link_rdata;
                    r_trav      <= r_list_head;
                    r_steps     <= '0;
                    if (r_mode == MODE_FRONT || !is_cell(r_list_head)) begin
                        r_list_head <= r_free_head;
                        r_state     <= S_DONE;
                    end else begin
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (walk_more) begin
                        r_trav  <= link_rdata;
                        r_steps <= r_steps + STEP_W'(1);
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!o_out_valid || !i_out_stall) begin
                        o_out_valid <= 1'b1;
                        o_status    <= r_res_status;
                        o_cell_used <= r_res_cell;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `CLFP_NEVER(a_steps_bound, i_clk, i_rst_n, r_steps > STEP_W'(POOL_CELLS), "walk ran past the pool size")
    `CLFP_NEVER(a_heads_coded, i_clk, i_rst_n, (r_free_head > NULL_LINK) || (r_list_head > NULL_LINK), "list head holds a code beyond null")
    `CLFP_ASSERT(a_walk_on_cell, i_clk, i_rst_n, (r_state == S_WALK) |-> is_cell(r_trav), "walk stands on a null link")
    `CLFP_ASSERT(a_write_marks_valid, i_clk, i_rst_n, link_we |=> r_link_valid[$past(link_waddr)], "written link entry not marked valid")

endmodule
`default_nettype wire
